// ===== rtl/core/tpta_pkg.sv =====
// ----------------------------------------------------------------------------
// tpta_pkg
// Shared types, constants and the arctangent table of the tilt angle solver.
// ----------------------------------------------------------------------------
package tpta_pkg;

  localparam int COORD_BITS_DEF   = 24;
  localparam int CORDIC_ITERS_DEF = 20;

  localparam int COORD_IN_W = 24;
  localparam int SLOT_W     = 2;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;
  localparam int SPD_W      = 24;
  localparam int ANGLE_W    = 19;
  localparam int ANG_MAG_W  = 17;
  localparam int STEP_W     = 16;
  localparam int ITER_W     = 5;
  localparam int ATAN_W     = 24;
  localparam int ACC_W      = 27;
  localparam int NORM_BITS  = 30;
  localparam int SQRT_STEPS = 31;

  // x / 125 as (x * ceil(2^30 / 125)) >> 30, exact for x below 2^23
  localparam int                 RECIP_W    = 24;
  localparam logic [RECIP_W-1:0] DIV125_MUL = 24'd8589935;
  localparam int                 DIV125_SH  = 30;

  localparam logic [SPD_W-1:0] SPD_RESET = 24'd65536;
  localparam logic             REQ_STORE   = 1'b0;
  localparam logic             REQ_COMPUTE = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE, OP_STORE, OP_LOAD, OP_SQ_U, OP_SQ_V, OP_SQ_ADD, OP_SQRT, OP_CINIT,
    OP_CORDIC, OP_ANGLE, OP_SMUL, OP_SDIV_INIT, OP_SDIV, OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic                axis;
    logic [ITER_W-1:0]   iter;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] upd;
  } dp_stat_t;

  // atan(2^-i) in 1/256 millidegree
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [ITER_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 24'd11520000;
      5'd1:  v = 24'd6800653;
      5'd2:  v = 24'd3593278;
      5'd3:  v = 24'd1824004;
      5'd4:  v = 24'd915542;
      5'd5:  v = 24'd458217;
      5'd6:  v = 24'd229164;
      5'd7:  v = 24'd114589;
      5'd8:  v = 24'd57295;
      5'd9:  v = 24'd28648;
      5'd10: v = 24'd14324;
      5'd11: v = 24'd7162;
      5'd12: v = 24'd3581;
      5'd13: v = 24'd1790;
      5'd14: v = 24'd895;
      5'd15: v = 24'd448;
      5'd16: v = 24'd224;
      5'd17: v = 24'd112;
      5'd18: v = 24'd56;
      5'd19: v = 24'd28;
      5'd20: v = 24'd14;
      5'd21: v = 24'd7;
      5'd22: v = 24'd3;
      5'd23: v = 24'd2;
      5'd24: v = 24'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/tpta_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpta_ctrl
// Sequencer: walks both axes through load, square root, CORDIC, step scaling.
// ----------------------------------------------------------------------------
module tpta_ctrl #(
  parameter int CORDIC_ITERS = tpta_pkg::CORDIC_ITERS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_kind_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  tpta_pkg::dp_stat_t stat_i,
  output tpta_pkg::dp_cmd_t  cmd_o
);
  import tpta_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_CHECK, ST_SQ_U, ST_SQ_V, ST_SQ_ADD, ST_SQRT, ST_CINIT,
    ST_CORDIC, ST_ANGLE, ST_SMUL, ST_SDIV_INIT, ST_SDIV, ST_EMIT
  } state_e;

  state_e            state_q;
  logic              axis_q;
  logic [ITER_W-1:0] iter_q;
  logic              out_valid_q;
  logic              emit_ok;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign emit_ok     = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.axis = axis_q;
    cmd_o.iter = iter_q;
    case (state_q)
      ST_IDLE:      cmd_o.op = (in_valid_i && in_kind_i == REQ_STORE) ? OP_STORE : OP_NONE;
      ST_LOAD:      cmd_o.op = OP_LOAD;
      ST_SQ_U:      cmd_o.op = OP_SQ_U;
      ST_SQ_V:      cmd_o.op = OP_SQ_V;
      ST_SQ_ADD:    cmd_o.op = OP_SQ_ADD;
      ST_SQRT:      cmd_o.op = OP_SQRT;
      ST_CINIT:     cmd_o.op = OP_CINIT;
      ST_CORDIC:    cmd_o.op = OP_CORDIC;
      ST_ANGLE:     cmd_o.op = OP_ANGLE;
      ST_SMUL:      cmd_o.op = OP_SMUL;
      ST_SDIV_INIT: cmd_o.op = OP_SDIV_INIT;
      ST_SDIV:      cmd_o.op = OP_SDIV;
      ST_EMIT:      cmd_o.op = emit_ok ? OP_EMIT : OP_NONE;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_EMIT && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_kind_i == REQ_COMPUTE) begin
            state_q <= ST_LOAD;
            axis_q  <= 1'b0;
          end
        end
        ST_LOAD: state_q <= ST_CHECK;
        ST_CHECK: begin
          if (stat_i.upd[axis_q]) begin
            state_q <= ST_SQ_U;
          end else if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= ST_LOAD;
          end else begin
            axis_q  <= 1'b0;
            state_q <= ST_SMUL;
          end
        end
        ST_SQ_U:   state_q <= ST_SQ_V;
        ST_SQ_V:   state_q <= ST_SQ_ADD;
        ST_SQ_ADD: state_q <= ST_SQRT;
        ST_SQRT: begin
          if (iter_q == ITER_W'(SQRT_STEPS - 1)) begin
            iter_q  <= '0;
            state_q <= ST_CINIT;
          end else begin
            iter_q <= iter_q + 1'b1;
          end
        end
        ST_CINIT: state_q <= ST_CORDIC;
        ST_CORDIC: begin
          if (iter_q == ITER_W'(CORDIC_ITERS - 1)) begin
            iter_q  <= '0;
            state_q <= ST_ANGLE;
          end else begin
            iter_q <= iter_q + 1'b1;
          end
        end
        ST_ANGLE: begin
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= ST_LOAD;
          end else begin
            axis_q  <= 1'b0;
            state_q <= ST_SMUL;
          end
        end
        ST_SMUL:      state_q <= ST_SDIV_INIT;
        ST_SDIV_INIT: state_q <= ST_SDIV;
        ST_SDIV: begin
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= ST_SMUL;
          end else begin
            axis_q  <= 1'b0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_ok) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/tpta_datapath.sv =====
// ----------------------------------------------------------------------------
// tpta_datapath
// Point store, normalizer, shared squarer, bit-serial root, CORDIC, step scaler.
// ----------------------------------------------------------------------------
module tpta_datapath #(
  parameter int COORD_BITS = tpta_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tpta_pkg::dp_cmd_t              cmd_i,
  output tpta_pkg::dp_stat_t             stat_o,
  input  logic                           cfg_we_i,
  input  logic [tpta_pkg::SPD_W-1:0]     cfg_wdata_i,
  input  logic [tpta_pkg::SLOT_W-1:0]    slot_i,
  input  logic [tpta_pkg::COORD_IN_W-1:0] x_i,
  input  logic [tpta_pkg::COORD_IN_W-1:0] y_i,
  input  logic [tpta_pkg::COORD_IN_W-1:0] z_i,
  output logic [tpta_pkg::OUT_DATA_W-1:0] res_o
);
  import tpta_pkg::*;

  localparam int DW  = COORD_BITS + 1;
  localparam int SHW = $clog2(DW);
  localparam int PW  = 2 * NORM_BITS;
  localparam int RW  = PW + 2;
  localparam int CW  = NORM_BITS + 4;
  localparam int MPW = 42;
  localparam int DQW = 26;
  localparam int QPW = DQW - 3 + RECIP_W;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(23040000);

  logic signed [COORD_BITS-1:0] px_q [3];
  logic signed [COORD_BITS-1:0] py_q [3];
  logic signed [COORD_BITS-1:0] pz_q [3];
  logic signed [ANGLE_W-1:0]    held_q [2];
  logic [STEP_W-1:0]            stp_q [2];
  logic [SPD_W-1:0]             spd_q;
  logic [1:0]                   upd_q;
  logic                         neg_q;
  logic [NORM_BITS-1:0]         am_q, au_q, av_q;
  logic [PW-1:0]                prod_q;
  logic [PW:0]                  sum_q;
  logic [RW-1:0]                rem_q, root_q;
  logic signed [CW-1:0]         x_q, y_q;
  logic signed [ACC_W-1:0]      acc_q;
  logic [MPW-1:0]               mprod_q;
  logic [DQW-1:0]               dq_q;
  logic                         sat_q;
  logic [OUT_DATA_W-1:0]        out_q;

  logic signed [DW-1:0] m_s, u_s, v_s;
  logic [DW-1:0]        m_mag, u_mag, v_mag, top;
  logic [SHW-1:0]       sh;
  logic [6:0]           bsh;
  logic [RW-1:0]        sbit, trial;
  logic signed [CW-1:0] xs, ys;
  logic signed [ACC_W-1:0] at_s, cl;
  logic [ACC_W-1:0]     rnd;
  logic [ANG_MAG_W-1:0] ang_mag;
  logic signed [ANGLE_W-1:0] ang_s, hsel;
  logic [ANGLE_W-2:0]   hmag;
  logic [MPW:0]         mp_rnd;
  logic [DQW:0]         qv;
  logic [QPW-1:0]       qprod;
  logic [1:0]           fwd;

  assign stat_o.upd = upd_q;
  assign res_o      = out_q;

  always_comb begin
    if (!cmd_i.axis) begin
      m_s = DW'(px_q[1]) - DW'(px_q[0]);
      u_s = DW'(py_q[1]) - DW'(py_q[0]);
      v_s = DW'(pz_q[1]) - DW'(pz_q[0]);
    end else begin
      m_s = DW'(py_q[1]) - DW'(py_q[2]);
      u_s = DW'(px_q[1]) - DW'(px_q[2]);
      v_s = DW'(pz_q[2]) - DW'(pz_q[1]);
    end
    m_mag = m_s[DW-1] ? DW'(-m_s) : DW'(m_s);
    u_mag = u_s[DW-1] ? DW'(-u_s) : DW'(u_s);
    v_mag = v_s[DW-1] ? DW'(-v_s) : DW'(v_s);
    top   = m_mag;
    if (u_mag > top) top = u_mag;
    if (v_mag > top) top = v_mag;
    sh = '0;
    for (int k = NORM_BITS; k < DW; k++) begin
      if (top[k]) sh = SHW'(k - NORM_BITS + 1);
    end
  end

  always_comb begin
    bsh   = 7'(PW) - 7'({cmd_i.iter, 1'b0});
    sbit  = RW'(1) << bsh;
    trial = root_q + sbit;
    xs    = x_q >>> cmd_i.iter;
    ys    = y_q >>> cmd_i.iter;
    at_s  = ACC_W'(atan_lut(cmd_i.iter));
    if (acc_q < 0)            cl = '0;
    else if (acc_q > ACC_MAX) cl = ACC_MAX;
    else                      cl = acc_q;
    rnd     = ACC_W'(cl) + ACC_W'(128);
    ang_mag = ANG_MAG_W'(rnd >> 8);
    ang_s   = neg_q ? -ANGLE_W'(ang_mag) : ANGLE_W'(ang_mag);
    hsel    = held_q[cmd_i.axis];
    hmag    = hsel[ANGLE_W-1] ? (ANGLE_W-1)'(-hsel) : (ANGLE_W-1)'(hsel);
    mp_rnd  = (MPW+1)'(mprod_q) + (MPW+1)'(32768000);
    qv      = (DQW+1)'(mp_rnd >> 16);
    // qv / 1000 = (qv >> 3) / 125
    qprod   = dq_q[DQW-1:3] * DIV125_MUL;
    fwd[0]  = !held_q[0][ANGLE_W-1] && (held_q[0] != '0);
    fwd[1]  = !held_q[1][ANGLE_W-1] && (held_q[1] != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        px_q[i] <= '0;
        py_q[i] <= '0;
        pz_q[i] <= '0;
      end
      held_q[0] <= '0;
      held_q[1] <= '0;
      spd_q     <= SPD_RESET;
      upd_q     <= '0;
    end else begin
      if (cfg_we_i) spd_q <= cfg_wdata_i;
      case (cmd_i.op)
        OP_STORE: begin
          if (slot_i != 2'd3) begin
            px_q[slot_i] <= COORD_BITS'($signed(x_i));
            py_q[slot_i] <= COORD_BITS'($signed(y_i));
            pz_q[slot_i] <= COORD_BITS'($signed(z_i));
          end
        end
        OP_LOAD:  upd_q[cmd_i.axis] <= !m_s[DW-1] && (m_s != '0);
        OP_ANGLE: held_q[cmd_i.axis] <= ang_s;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        neg_q <= v_s[DW-1];
        am_q  <= NORM_BITS'(m_mag >> sh);
        au_q  <= NORM_BITS'(u_mag >> sh);
        av_q  <= NORM_BITS'(v_mag >> sh);
      end
      OP_SQ_U: prod_q <= au_q * au_q;
      OP_SQ_V: begin
        sum_q  <= (PW+1)'(prod_q);
        prod_q <= av_q * av_q;
      end
      OP_SQ_ADD: begin
        rem_q  <= RW'(sum_q) + RW'(prod_q);
        root_q <= '0;
      end
      OP_SQRT: begin
        if (rem_q >= trial) begin
          rem_q  <= rem_q - trial;
          root_q <= (root_q >> 1) + sbit;
        end else begin
          root_q <= root_q >> 1;
        end
      end
      OP_CINIT: begin
        x_q   <= CW'(am_q);
        y_q   <= CW'(root_q[NORM_BITS:0]);
        acc_q <= '0;
      end
      OP_CORDIC: begin
        if (!y_q[CW-1]) begin
          x_q   <= x_q + ys;
          y_q   <= y_q - xs;
          acc_q <= acc_q + at_s;
        end else begin
          x_q   <= x_q - ys;
          y_q   <= y_q + xs;
          acc_q <= acc_q - at_s;
        end
      end
      OP_SMUL: mprod_q <= hmag * spd_q;
      OP_SDIV_INIT: begin
        sat_q <= (qv >= (DQW+1)'(65536000));
        dq_q  <= DQW'(qv);
      end
      OP_SDIV: begin
        stp_q[cmd_i.axis] <= sat_q ? '1 : STEP_W'(qprod >> DIV125_SH);
      end
      OP_EMIT: begin
        out_q <= {6'd0, stp_q[1], stp_q[0], fwd[1], fwd[0], upd_q[1], upd_q[0],
                  held_q[1], held_q[0]};
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/three_point_tilt_angles.sv =====
// ----------------------------------------------------------------------------
// three_point_tilt_angles
// Tilt angles and motor step counts from three probed points.
// ----------------------------------------------------------------------------
// Input stream: tuser = request kind (0 store point, 1 compute); tdata holds
// slot and X/Y/Z. A store transaction is taken while idle and yields no
// output. A compute transaction yields one output transaction with both
// angles, the update and direction flags and both step counts.
// A compute runs from acceptance to m_axis_tvalid as follows: per updated
// axis a 31-step bit-serial square root and a CORDIC_ITERS-step CORDIC on
// one shared unit (an axis that is not updated is only loaded and checked),
// then per axis a multiply and a reciprocal scaling for the step counts.
// One item is in work at a time; s_axis_tready is high only while the
// sequencer is idle, so a new compute is taken only after the last one
// ends. The output register holds a finished result until m_axis_tready;
// the block keeps accepting stores meanwhile, and a following compute waits
// at its end for the register to free. Reset clears the points, held angles,
// and sets steps per degree to 1.0. cfg_we_i writes steps per degree; the
// user must write it only while idle; the block has no check of its own.
// ----------------------------------------------------------------------------
module three_point_tilt_angles #(
  parameter int COORD_BITS   = tpta_pkg::COORD_BITS_DEF,
  parameter int CORDIC_ITERS = tpta_pkg::CORDIC_ITERS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tpta_pkg::SPD_W-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // point_slot, x_coord, y_coord, z_coord
  input  logic [tpta_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tilt_a_mdeg, tilt_b_mdeg, a_updated, b_updated, a_forward, b_forward,
  // a_step_count, b_step_count
  output logic [tpta_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tpta_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tpta_ctrl #(
    .CORDIC_ITERS(CORDIC_ITERS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tpta_datapath #(
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .slot_i     (s_axis_tdata[1:0]),
    .x_i        (s_axis_tdata[25:2]),
    .y_i        (s_axis_tdata[49:26]),
    .z_i        (s_axis_tdata[73:50]),
    .res_o      (m_axis_tdata)
  );

endmodule

// ===== test/three_point_tilt_angles_checker.sv =====
// ----------------------------------------------------------------------------
// three_point_tilt_angles_checker
// Watches the configuration port and both streams of the tilt solver. It keeps
// its own copy of the probe points, held angles and steps per degree, predicts
// each result, and compares every output transaction field by field.
// ----------------------------------------------------------------------------
module three_point_tilt_angles_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tpta_pkg::SPD_W-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [tpta_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [tpta_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output int                              errors_o,
  output int                              pending_o,
  output int                              results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tpta_pkg::*;

  typedef struct packed {
    logic [STEP_W-1:0]  b_steps;
    logic [STEP_W-1:0]  a_steps;
    logic               b_fwd;
    logic               a_fwd;
    logic               b_upd;
    logic               a_upd;
    logic [ANGLE_W-1:0] angle_b;
    logic [ANGLE_W-1:0] angle_a;
  } tilt_result_t;

  localparam longint ATAN_STEP [0:24] = '{
    11520000, 6800653, 3593278, 1824004, 915542, 458217, 229164, 114589,
    57295, 28648, 14324, 7162, 3581, 1790, 895, 448,
    224, 112, 56, 28, 14, 7, 3, 2, 1};

  longint           px [3];
  longint           py [3];
  longint           pz [3];
  int               angle_a_q;
  int               angle_b_q;
  longint unsigned  spd_q;
  tilt_result_t     expected_results [$];

  assign pending_o = expected_results.size();

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // atan2(sqrt(u^2+v^2), m) in millidegrees, m > 0
  function automatic int tilt_mdeg(longint m, longint u, longint v);
    longint unsigned am, au, av, top;
    longint x, y, xo, acc;
    int s;
    am = abs64(m);
    au = abs64(u);
    av = abs64(v);
    top = am;
    if (au > top) top = au;
    if (av > top) top = av;
    s = 0;
    while ((top >> s) >= (64'd1 << NORM_BITS)) s++;
    am >>= s;
    au >>= s;
    av >>= s;
    x = am;
    y = root_floor(au * au + av * av);
    acc = 0;
    for (int i = 0; i < CORDIC_ITERS_DEF; i++) begin
      xo = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (xo >>> i);
        acc += (i < 25) ? ATAN_STEP[i] : 0;
      end else begin
        x = x - (y >>> i);
        y = y + (xo >>> i);
        acc -= (i < 25) ? ATAN_STEP[i] : 0;
      end
    end
    if (acc < 0) acc = 0;
    if (acc > 64'sd90000 * 256) acc = 64'sd90000 * 256;
    return int'((acc + 128) >>> 8);
  endfunction

  function automatic logic [STEP_W-1:0] steps_for(int ang);
    longint unsigned st;
    st = (abs64(longint'(ang)) * spd_q + 64'd32768000) / 64'd65536000;
    return st > 65535 ? 16'hFFFF : st[STEP_W-1:0];
  endfunction

  function automatic tilt_result_t solve_tilt();
    tilt_result_t r;
    longint e1x, e1y, e1z, e2x, e2y, e2z;
    int a;
    e1x = px[1] - px[0];
    e1y = py[1] - py[0];
    e1z = pz[1] - pz[0];
    e2x = px[1] - px[2];
    e2y = py[1] - py[2];
    e2z = pz[2] - pz[1];
    r = '0;
    if (e1x > 0) begin
      a = tilt_mdeg(e1x, e1y, e1z);
      angle_a_q = e1z < 0 ? -a : a;
      r.a_upd = 1'b1;
    end
    if (e2y > 0) begin
      a = tilt_mdeg(e2y, e2x, e2z);
      angle_b_q = e2z < 0 ? -a : a;
      r.b_upd = 1'b1;
    end
    r.angle_a = angle_a_q[ANGLE_W-1:0];
    r.angle_b = angle_b_q[ANGLE_W-1:0];
    r.a_fwd   = angle_a_q > 0;
    r.b_fwd   = angle_b_q > 0;
    r.a_steps = steps_for(angle_a_q);
    r.b_steps = steps_for(angle_b_q);
    return r;
  endfunction

  task automatic report(string field, longint unsigned exp_v, longint unsigned act_v);
    errors_o++;
    $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tilt_result_t e, got;
    logic [1:0] slot;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        px[i] = 0;
        py[i] = 0;
        pz[i] = 0;
      end
      angle_a_q = 0;
      angle_b_q = 0;
      spd_q = 64'(SPD_RESET);
      expected_results.delete();
      errors_o = 0;
      results_o = 0;
    end else begin
      if (cfg_we_i) spd_q = 64'(cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == REQ_COMPUTE) begin
          expected_results.push_back(solve_tilt());
        end else begin
          slot = s_axis_tdata[1:0];
          if (slot < 3) begin
            px[slot] = longint'($signed(s_axis_tdata[25:2]));
            py[slot] = longint'($signed(s_axis_tdata[49:26]));
            pz[slot] = longint'($signed(s_axis_tdata[73:50]));
          end
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(tilt_result_t)-1:0];
        results_o++;
        if (expected_results.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected output transaction, actual %h", $time, got);
        end else begin
          e = expected_results.pop_front();
          if (got.angle_a !== e.angle_a) report("tilt_a_mdeg", e.angle_a, got.angle_a);
          if (got.angle_b !== e.angle_b) report("tilt_b_mdeg", e.angle_b, got.angle_b);
          if (got.a_upd !== e.a_upd) report("a_updated", e.a_upd, got.a_upd);
          if (got.b_upd !== e.b_upd) report("b_updated", e.b_upd, got.b_upd);
          if (got.a_fwd !== e.a_fwd) report("a_forward", e.a_fwd, got.a_fwd);
          if (got.b_fwd !== e.b_fwd) report("b_forward", e.b_fwd, got.b_fwd);
          if (got.a_steps !== e.a_steps) report("a_step_count", e.a_steps, got.a_steps);
          if (got.b_steps !== e.b_steps) report("b_step_count", e.b_steps, got.b_steps);
        end
      end
    end
  end

endmodule

// ===== test/three_point_tilt_angles_test.sv =====
// ----------------------------------------------------------------------------
// three_point_tilt_angles_test
// Drives store and compute transactions into the tilt solver under changing
// stalls and steps-per-degree settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module three_point_tilt_angles_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tpta_pkg::*;

  localparam int SETTLE = 400;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [SPD_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  int                    errors;
  int                    pending;
  int                    results;
  int                    send_idle;
  int                    recv_idle;
  int                    n_items;
  int                    n_settings;

  three_point_tilt_angles uut (.*);

  three_point_tilt_angles_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send(logic kind, logic [1:0] slot, logic [23:0] x, logic [23:0] y,
                      logic [23:0] z);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'b0, z, y, x, slot};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    n_items++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_spd(logic [SPD_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [23:0] any_coord();
    case ($urandom_range(3))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // offset of random magnitude, either sign
  function automatic logic [23:0] near(logic [23:0] base);
    int sh;
    sh = $urandom_range(22);
    return 24'(32'(base) + (($urandom & ((32'd1 << sh) - 1)) ^
                            ($urandom_range(1) ? 32'hFFFFFFFF : 32'h0)));
  endfunction

  task automatic well_formed_set();
    logic [23:0] bx, by, bz;
    bx = $urandom_range(1) ? any_coord() : 24'($urandom_range(4000) - 2000);
    by = $urandom_range(1) ? any_coord() : 24'($urandom_range(4000) - 2000);
    bz = $urandom_range(1) ? any_coord() : 24'($urandom_range(4000) - 2000);
    for (int s = 0; s < 3; s++) begin
      if ($urandom_range(5) != 0) send(REQ_STORE, 2'(s), near(bx), near(by), near(bz));
    end
    send(REQ_COMPUTE, 2'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    if ($urandom_range(4) == 0) begin
      send(REQ_COMPUTE, 2'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    end
  endtask

  task automatic random_run(int count);
    int start;
    start = n_items;
    while (n_items - start < count) begin
      if ($urandom_range(4) != 0) begin
        well_formed_set();
      end else begin
        send(1'($urandom_range(1)), 2'($urandom), any_coord(), any_coord(), any_coord());
      end
      if (n_items - start > count / 2 && n_items - start < count / 2 + 5) drain();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_STORE;
    send_idle     = 0;
    recv_idle     = 0;
    n_items       = 0;
    n_settings    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // compute on reset points, then on extreme and degenerate geometries
    send(REQ_COMPUTE, 2'd0, 24'd0, 24'd0, 24'd0);
    send(REQ_STORE, 2'd0, 24'h800000, 24'h800000, 24'h800000);
    send(REQ_STORE, 2'd1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send(REQ_STORE, 2'd2, 24'h800000, 24'h800000, 24'h7FFFFF);
    send(REQ_COMPUTE, 2'd3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send(REQ_STORE, 2'd3, 24'h123456, 24'h654321, 24'h0F0F0F);
    send(REQ_COMPUTE, 2'd0, 24'd0, 24'd0, 24'd0);
    send(REQ_STORE, 2'd0, 24'd0, 24'd0, 24'd0);
    send(REQ_STORE, 2'd1, 24'd1000, 24'd0, 24'hFFFE0C);
    send(REQ_STORE, 2'd2, 24'd0, 24'hFFFC18, 24'd1000);
    send(REQ_COMPUTE, 2'd0, 24'd0, 24'd0, 24'd0);
    send(REQ_STORE, 2'd1, 24'hFFFC18, 24'd0, 24'd0);
    send(REQ_STORE, 2'd2, 24'd0, 24'd1000, 24'd0);
    send(REQ_COMPUTE, 2'd0, 24'd0, 24'd0, 24'd0);
    send(REQ_STORE, 2'd1, 24'd1, 24'h7FFFFF, 24'h7FFFFF);
    send(REQ_STORE, 2'd2, 24'd0, 24'd0, 24'h800000);
    send(REQ_COMPUTE, 2'd0, 24'd0, 24'd0, 24'd0);
    set_spd(24'hFFFFFF);
    send(REQ_COMPUTE, 2'd0, 24'd0, 24'd0, 24'd0);
    set_spd('0);
    send(REQ_COMPUTE, 2'd0, 24'd0, 24'd0, 24'd0);

    set_spd(SPD_RESET);
    send_idle = 37;
    recv_idle = 60;
    random_run(700);
    set_spd(SPD_W'($urandom_range(24'hFFFFFF)));
    send_idle = 60;
    recv_idle = 37;
    random_run(700);
    set_spd(SPD_W'($urandom_range(24'h3FFFFF)));
    send_idle = 0;
    recv_idle = 0;
    random_run(600);
    drain();

    $display("%0d input transactions, %0d results checked, %0d steps-per-degree settings",
             n_items, results, n_settings);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tpta_pkg.sv
rtl/core/tpta_ctrl.sv
rtl/core/tpta_datapath.sv
rtl/core/three_point_tilt_angles.sv
test/three_point_tilt_angles_checker.sv
test/three_point_tilt_angles_test.sv
